[design/button_press_classifier_unit_assert.svh]
// Assertion macros for the button press classifier.
`ifndef BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_PRESS_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define BPC_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

`define BPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define BPC_ASSERT(lbl, clk, rst, prop)

`define BPC_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

[design/bpc_pkg.sv]
// Types and constants shared by the button press classifier files.
package bpc_pkg;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INITIAL  = 3'd1;
  localparam logic [2:0] ST_DEBOUNCE = 3'd2;
  localparam logic [2:0] ST_PRESSED  = 3'd3;
  localparam logic [2:0] ST_REPEAT   = 3'd4;
  localparam logic [2:0] ST_WAITLONG = 3'd5;
  localparam logic [2:0] ST_WAITREL  = 3'd6;

  localparam logic [1:0] EV_NORMAL   = 2'd0;
  localparam logic [1:0] EV_REPEAT   = 2'd1;
  localparam logic [1:0] EV_LONG     = 2'd2;
  localparam logic [1:0] EV_RELEASED = 2'd3;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_START  = 2'd1;
  localparam logic [1:0] OP_STOP   = 2'd2;

  localparam logic [1:0] MODE_SIMPLE     = 2'd0;
  localparam logic [1:0] MODE_CONTINUOUS = 2'd1;
  localparam logic [1:0] MODE_LONG       = 2'd2;

  localparam logic [2:0] REG_ACTIVE_LEVEL = 3'd0;
  localparam logic [2:0] REG_DEBOUNCE     = 3'd1;
  localparam logic [2:0] REG_NORMAL_PRESS = 3'd2;
  localparam logic [2:0] REG_REPEAT       = 3'd3;
  localparam logic [2:0] REG_LONG_PRESS   = 3'd4;
  localparam logic [2:0] REG_PRESS_MODE   = 3'd5;

  typedef struct packed {
    logic        active_level;
    logic [15:0] debounce_ms;
    logic [15:0] normal_press_ms;
    logic [15:0] repeat_interval_ms;
    logic [15:0] long_press_ms;
    logic [1:0]  press_mode;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  fsm_state;
    logic [31:0] last_event_time;
    logic        event_valid;
    logic [1:0]  event_kind;
  } step_res_t;

endpackage

[design/button_press_classifier_unit.sv]
// Button press classifier: debounce, normal, repeat and long press, release events.
// Accepts one item (start, stop or pin sample) per clock unless the result register
// stalls, and returns one result per item, held first in the input register and
// then in the result register. The sustained rate is one item per cycle; it is set
// by the state and last-event-time registers, which close one compare-and-subtract
// loop per item. A stalled result register holds the next item in the input register.
// Writes to config registers 0 to 5 return the state machine to idle.
`include "button_press_classifier_unit_assert.svh"
module button_press_classifier_unit import bpc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pin_level [0], now_ms [32:1], zero fill
  input  logic [1:0]  s_tuser,   // operation [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // event_valid [0], zero fill
  output logic [1:0]  m_tuser    // event_kind [1:0]
);

  cfg_t        cfg;
  logic [2:0]  fsm_state;
  logic [31:0] last_event_time;
  logic        in_valid;
  logic [1:0]  in_op;
  logic        in_pin;
  logic [31:0] in_now;
  logic        out_valid;
  logic        out_event_valid;
  logic [1:0]  out_event_kind;
  logic        advance;
  logic        cfg_hit;
  step_res_t   res;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_hit  = cfg_we && (cfg_index <= REG_PRESS_MODE);

  bpc_step u_step (
    .cfg             (cfg),
    .fsm_state       (fsm_state),
    .last_event_time (last_event_time),
    .operation       (in_op),
    .pin_level       (in_pin),
    .now_ms          (in_now),
    .res             (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.active_level       <= 1'b0;
      cfg.debounce_ms        <= 16'd20;
      cfg.normal_press_ms    <= 16'd50;
      cfg.repeat_interval_ms <= 16'd200;
      cfg.long_press_ms      <= 16'd1000;
      cfg.press_mode         <= MODE_SIMPLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_LEVEL: cfg.active_level       <= cfg_data[0];
        REG_DEBOUNCE:     cfg.debounce_ms        <= cfg_data;
        REG_NORMAL_PRESS: cfg.normal_press_ms    <= cfg_data;
        REG_REPEAT:       cfg.repeat_interval_ms <= cfg_data;
        REG_LONG_PRESS:   cfg.long_press_ms      <= cfg_data;
        REG_PRESS_MODE:   cfg.press_mode         <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm_state       <= ST_IDLE;
      last_event_time <= 32'd0;
    end else if (cfg_hit) begin
      fsm_state <= ST_IDLE;
    end else if (advance) begin
      fsm_state       <= res.fsm_state;
      last_event_time <= res.last_event_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_op  <= s_tuser;
      in_pin <= s_tdata[0];
      in_now <= s_tdata[32:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_event_valid <= res.event_valid;
      out_event_kind  <= res.event_kind;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {7'd0, out_event_valid};
  assign m_tuser  = out_event_kind;

  `BPC_ASSERT_NEXT(a_cfg_idle, clk, rst, cfg_hit, fsm_state == ST_IDLE)
  `BPC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !m_tready,
                   out_valid && $stable(m_tdata) && $stable(m_tuser))
  `BPC_ASSERT(a_no_event_kind, clk, rst,
              !(out_valid && !out_event_valid) || (out_event_kind == EV_NORMAL))
  `BPC_ASSERT_NEXT(a_normal_next, clk, rst,
                   advance && !cfg_hit && res.event_valid && res.event_kind == EV_NORMAL,
                   fsm_state == ST_REPEAT || fsm_state == ST_WAITLONG ||
                   fsm_state == ST_WAITREL)
  `BPC_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !advance, in_valid)

endmodule

[design/bpc_step.sv]
// Next-state and event logic for one classifier item.
module bpc_step import bpc_pkg::*; (
  input  cfg_t        cfg,
  input  logic [2:0]  fsm_state,
  input  logic [31:0] last_event_time,
  input  logic [1:0]  operation,
  input  logic        pin_level,
  input  logic [31:0] now_ms,
  output step_res_t   res
);

  logic [15:0] limit;
  logic [31:0] elapsed;
  logic        reached;
  logic        pressed;
  logic [2:0]  mode_state;

  always_comb begin
    unique case (fsm_state)
      ST_PRESSED:  limit = cfg.normal_press_ms;
      ST_REPEAT:   limit = cfg.repeat_interval_ms;
      ST_WAITLONG: limit = cfg.long_press_ms;
      default:     limit = cfg.debounce_ms;
    endcase
  end

  assign elapsed = now_ms - last_event_time;
  assign reached = elapsed > {16'd0, limit};
  assign pressed = pin_level == cfg.active_level;

  always_comb begin
    unique case (cfg.press_mode)
      MODE_CONTINUOUS: mode_state = ST_REPEAT;
      MODE_LONG:       mode_state = ST_WAITLONG;
      default:         mode_state = ST_WAITREL;
    endcase
  end

  always_comb begin
    res.fsm_state       = fsm_state;
    res.last_event_time = last_event_time;
    res.event_valid     = 1'b0;
    res.event_kind      = EV_NORMAL;
    unique case (operation)
      OP_START: res.fsm_state = ST_INITIAL;
      OP_STOP:  res.fsm_state = ST_IDLE;
      OP_SAMPLE: begin
        unique case (fsm_state)
          ST_INITIAL: begin
            if (pressed) begin
              res.last_event_time = now_ms;
              res.fsm_state       = ST_DEBOUNCE;
            end
          end
          ST_DEBOUNCE: begin
            if (!pressed) begin
              res.fsm_state = ST_INITIAL;
            end else if (reached) begin
              res.last_event_time = now_ms;
              res.fsm_state       = ST_PRESSED;
            end
          end
          ST_PRESSED: begin
            if (!pressed) begin
              res.fsm_state = ST_INITIAL;
            end else if (reached) begin
              res.event_valid     = 1'b1;
              res.event_kind      = EV_NORMAL;
              res.last_event_time = now_ms;
              res.fsm_state       = mode_state;
            end
          end
          ST_REPEAT: begin
            if (!pressed) begin
              res.fsm_state = ST_WAITREL;
            end else if (reached) begin
              res.event_valid     = 1'b1;
              res.event_kind      = EV_REPEAT;
              res.last_event_time = now_ms;
            end
          end
          ST_WAITLONG: begin
            if (!pressed) begin
              res.fsm_state = ST_WAITREL;
            end else if (reached) begin
              res.event_valid     = 1'b1;
              res.event_kind      = EV_LONG;
              res.last_event_time = now_ms;
              res.fsm_state       = ST_WAITREL;
            end
          end
          ST_WAITREL: begin
            if (!pressed && reached) begin
              res.event_valid = 1'b1;
              res.event_kind  = EV_RELEASED;
              res.fsm_state   = ST_INITIAL;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

endmodule
